// ===== rtl/pin_report_message_parser_unit_defines.svh =====
// Assertion macros for the pin report message parser
`ifndef PIN_REPORT_MESSAGE_PARSER_UNIT_DEFINES_SVH
`define PIN_REPORT_MESSAGE_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PMP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PMP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define PMP_ASSERT(lbl, clk, rstn, prop, msg)
`define PMP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/pmp_pkg.sv =====
`default_nettype none

package pmp_pkg;

    localparam int FRAME_DEPTH = 256;
    localparam int PIN_COUNT   = 128;
    localparam int FA_W        = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 2);
    localparam int PA_W        = $clog2(PIN_COUNT);
    localparam int SH_N        = 7;

    localparam logic [7:0] B_SYSEX_BEGIN  = 8'hF0;
    localparam logic [7:0] B_SYSEX_END    = 8'hF7;
    localparam logic [7:0] B_REPORT_VER   = 8'hF9;
    localparam logic [7:0] SUB_ANALOG_MAP = 8'h6A;
    localparam logic [7:0] SUB_PIN_STATE  = 8'h6E;
    localparam logic [3:0] HI_ANALOG      = 4'hE;
    localparam logic [3:0] HI_DIGITAL     = 4'h9;
    localparam logic [3:0] HI_PROG        = 4'hC;
    localparam logic [3:0] HI_CHPRES      = 4'hD;
    localparam logic [6:0] MODE_IN        = 7'd0;
    localparam logic [6:0] CH_NONE        = 7'd127;
    localparam logic       EV_CHANGED     = 1'b0;
    localparam logic       EV_FOUND       = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [6:0]  pin;
        logic [20:0] value;
        logic [6:0]  mode;
    } pin_ev_t;

    typedef struct packed {
        logic [PA_W-1:0] rd_addr;
        logic            mv_we;
        logic            ch_we;
        logic [PA_W-1:0] wr_addr;
        logic [6:0]      mode;
        logic [20:0]     value;
        logic [6:0]      channel;
    } pin_req_t;

    typedef struct packed {
        logic [6:0]  mode;
        logic [20:0] value;
        logic [6:0]  channel;
    } pin_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pmp_if.sv =====
`default_nettype none

interface pmp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface pmp_ev_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [6:0]  pin_number;
    logic [20:0] pin_value;
    logic [6:0]  pin_mode;
    logic        last_event;
    modport source (output valid, output event_kind, output pin_number, output pin_value,
                    output pin_mode, output last_event, input ready);
    modport sink (input valid, input event_kind, input pin_number, input pin_value,
                  input pin_mode, input last_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/pin_report_message_parser_unit.sv =====
// Pin report message parser. Takes one received protocol byte per request on rx and
// reports pin table updates on ev. After a byte that does not complete a frame, rx
// stays ready. A completed frame is decoded with rx held not ready: an analog message
// scans the pin table through its single read port, a read and a check state per pin,
// until the first pin on its channel; a digital port message checks its eight pins with
// a read and a check state each; an analog mapping reply reads the frame buffer with a
// read and a write state per mapped byte; a pin state reply is written during dispatch.
// Every completed frame also passes through dispatch and flush; the digital check and
// the flush wait while the ev side holds off a waiting event. Events go out in pin
// order, and last_event marks the final event of the byte that completed the frame.
`default_nettype none

`include "pin_report_message_parser_unit_defines.svh"

module pin_report_message_parser_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    pmp_rx_if.sink    rx,
    pmp_ev_if.source  ev
);
    import pmp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_A_RD  = 4'd2;
    localparam logic [3:0] ST_A_CHK = 4'd3;
    localparam logic [3:0] ST_D_RD  = 4'd4;
    localparam logic [3:0] ST_D_CHK = 4'd5;
    localparam logic [3:0] ST_M_RD  = 4'd6;
    localparam logic [3:0] ST_M_WR  = 4'd7;
    localparam logic [3:0] ST_FLUSH = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] exp_reg, exp_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [7:0]       sh_reg [SH_N];
    logic [7:0]       sh_next [SH_N];
    logic [7:0]       last_reg, last_next;
    logic [PA_W-1:0]  idx_reg, idx_next;
    logic [2:0]       bcnt_reg, bcnt_next;
    logic [CNT_W-1:0] mi_reg, mi_next;
    logic [3:0]       ch_reg, ch_next;
    logic [20:0]      val_reg, val_next;
    logic             pend_valid_reg, pend_valid_next;
    pin_ev_t          pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    pin_ev_t          out_reg, out_next;
    logic             out_last_reg, out_last_next;

    pin_req_t         req;
    pin_rsp_t         rsp;
    logic             fb_we;
    logic [FA_W-1:0]  fb_wa;
    logic [7:0]       fb_rd;

    logic [3:0]       hi;
    logic [CNT_W-1:0] cnt0, cnt1, exp1, mp;
    logic             store, done, out_free, blocked, prod, pbit;
    logic [6:0]       dig_pin;
    logic [7:0]       port_lo;
    logic [20:0]      ps_val;
    pin_ev_t          prod_ev;

    pmp_frame_buf u_frame (
        .clk     (clk),
        .wr_en   (fb_we),
        .wr_addr (fb_wa),
        .wr_data (rx.rx_byte),
        .rd_addr (mi_reg[FA_W-1:0]),
        .rd_data (fb_rd)
    );

    pmp_pin_tbl u_pins (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign rx.ready      = (state_reg == ST_IDLE);
    assign ev.valid      = out_valid_reg;
    assign ev.event_kind = out_reg.kind;
    assign ev.pin_number = out_reg.pin;
    assign ev.pin_value  = out_reg.value;
    assign ev.pin_mode   = out_reg.mode;
    assign ev.last_event = out_last_reg;

    always_comb
    begin
        hi   = rx.rx_byte[7:4];
        cnt0 = cnt_reg;
        exp1 = exp_reg;
        priority if (hi == HI_ANALOG || hi == HI_DIGITAL || rx.rx_byte == B_REPORT_VER)
        begin
            exp1 = CNT_W'(3);
            cnt0 = '0;
        end
        else if (hi == HI_PROG || hi == HI_CHPRES)
        begin
            exp1 = CNT_W'(2);
            cnt0 = '0;
        end
        else if (rx.rx_byte == B_SYSEX_BEGIN)
        begin
            exp1 = CNT_W'(FRAME_DEPTH);
            cnt0 = '0;
        end
        else if (rx.rx_byte == B_SYSEX_END)
        begin
            exp1 = cnt_reg + CNT_W'(1);
        end
        else if (rx.rx_byte[7])
        begin
            exp1 = CNT_W'(1);
            cnt0 = '0;
        end
        else
        begin
            exp1 = exp_reg;
        end
        store = (32'(cnt0) < FRAME_DEPTH);
        cnt1  = store ? cnt0 + CNT_W'(1) : cnt0;
        done  = (cnt1 == exp1);

        out_free = !out_valid_reg || ev.ready;
        blocked  = pend_valid_reg && !out_free;
        dig_pin  = {sh_reg[0][3:0], bcnt_reg};
        port_lo  = sh_reg[1] | {sh_reg[2][0], 7'd0};
        pbit     = port_lo[bcnt_reg];
        mp       = mi_reg - CNT_W'(2);
        ps_val   = 21'(sh_reg[4]);
        if (n_reg > CNT_W'(6))
        begin
            ps_val = ps_val | (21'(sh_reg[5]) << 7);
        end
        if (n_reg > CNT_W'(7))
        begin
            ps_val = ps_val | (21'(sh_reg[6]) << 14);
        end

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        exp_next        = exp_reg;
        n_next          = n_reg;
        sh_next         = sh_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        bcnt_next       = bcnt_reg;
        mi_next         = mi_reg;
        ch_next         = ch_reg;
        val_next        = val_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !ev.ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        req             = '0;
        req.rd_addr     = idx_reg;
        fb_we           = 1'b0;
        fb_wa           = cnt0[FA_W-1:0];
        prod            = 1'b0;
        prod_ev         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx.valid)
                begin
                    fb_we     = store;
                    last_next = rx.rx_byte;
                    if (store && 32'(cnt0) < SH_N)
                    begin
                        sh_next[cnt0[2:0]] = rx.rx_byte;
                    end
                    if (done)
                    begin
                        cnt_next   = '0;
                        exp_next   = '0;
                        n_next     = cnt1;
                        state_next = ST_DISP;
                    end
                    else
                    begin
                        cnt_next = cnt1;
                        exp_next = exp1;
                    end
                end
            end
            ST_DISP:
            begin
                state_next = ST_FLUSH;
                if (sh_reg[0][7:4] == HI_ANALOG && n_reg == CNT_W'(3))
                begin
                    ch_next    = sh_reg[0][3:0];
                    val_next   = 21'(sh_reg[1]) | (21'(sh_reg[2]) << 7);
                    idx_next   = '0;
                    state_next = ST_A_RD;
                end
                else if (sh_reg[0][7:4] == HI_DIGITAL && n_reg == CNT_W'(3))
                begin
                    bcnt_next  = '0;
                    state_next = ST_D_RD;
                end
                else if (sh_reg[0] == B_SYSEX_BEGIN && n_reg >= CNT_W'(2)
                         && last_reg == B_SYSEX_END)
                begin
                    if (sh_reg[1] == SUB_ANALOG_MAP)
                    begin
                        mi_next = CNT_W'(2);
                        if (n_reg > CNT_W'(3))
                        begin
                            state_next = ST_M_RD;
                        end
                    end
                    else if (sh_reg[1] == SUB_PIN_STATE && n_reg >= CNT_W'(6)
                             && 32'(sh_reg[2]) < PIN_COUNT)
                    begin
                        req.mv_we   = 1'b1;
                        req.wr_addr = sh_reg[2][PA_W-1:0];
                        req.mode    = sh_reg[3][6:0];
                        req.value   = ps_val;
                        prod        = 1'b1;
                        prod_ev     = '{EV_FOUND, sh_reg[2][6:0], ps_val, sh_reg[3][6:0]};
                    end
                end
            end
            ST_A_RD:
            begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (rsp.channel == {3'd0, ch_reg})
                begin
                    req.mv_we   = 1'b1;
                    req.wr_addr = idx_reg;
                    req.mode    = rsp.mode;
                    req.value   = val_reg;
                    prod        = 1'b1;
                    prod_ev     = '{EV_CHANGED, 7'(idx_reg), val_reg, rsp.mode};
                    state_next  = ST_FLUSH;
                end
                else if (32'(idx_reg) == PIN_COUNT - 1)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next   = idx_reg + PA_W'(1);
                    state_next = ST_A_RD;
                end
            end
            ST_D_RD:
            begin
                req.rd_addr = dig_pin[PA_W-1:0];
                if (32'(dig_pin) < PIN_COUNT)
                begin
                    state_next = ST_D_CHK;
                end
                else if (bcnt_reg == 3'd7)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    bcnt_next = bcnt_reg + 3'd1;
                end
            end
            ST_D_CHK:
            begin
                req.rd_addr = dig_pin[PA_W-1:0];
                if (!(rsp.mode == MODE_IN && rsp.value != 21'(pbit)) || !blocked)
                begin
                    if (rsp.mode == MODE_IN && rsp.value != 21'(pbit))
                    begin
                        req.mv_we   = 1'b1;
                        req.wr_addr = dig_pin[PA_W-1:0];
                        req.mode    = rsp.mode;
                        req.value   = 21'(pbit);
                        prod        = 1'b1;
                        prod_ev     = '{EV_CHANGED, dig_pin, 21'(pbit), rsp.mode};
                    end
                    if (bcnt_reg == 3'd7)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bcnt_next  = bcnt_reg + 3'd1;
                        state_next = ST_D_RD;
                    end
                end
            end
            ST_M_RD:
            begin
                state_next = ST_M_WR;
            end
            ST_M_WR:
            begin
                if (32'(mp) < PIN_COUNT)
                begin
                    req.ch_we   = 1'b1;
                    req.wr_addr = PA_W'(mp);
                    req.channel = fb_rd[6:0];
                end
                mi_next = mi_reg + CNT_W'(1);
                if (32'(mi_reg) + 32'd2 < 32'(n_reg))
                begin
                    state_next = ST_M_RD;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the newest event back until the next one or the flush decides last_event
        if (prod)
        begin
            if (!pend_valid_reg)
            begin
                pend_valid_next = 1'b1;
                pend_next       = prod_ev;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                pend_next      = prod_ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            exp_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            exp_reg        <= exp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        sh_reg       <= sh_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        bcnt_reg     <= bcnt_next;
        mi_reg       <= mi_next;
        ch_reg       <= ch_next;
        val_reg      <= val_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    `PMP_ASSERT_IMP(a_idle_no_pend, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg, "event left pending in idle")
    `PMP_ASSERT(a_cnt_bound, clk, rst_n, 32'(cnt_reg) <= FRAME_DEPTH, "byte count past frame depth")
    `PMP_ASSERT_IMP(a_dig_pin_range, clk, rst_n, state_reg == ST_D_CHK, 32'(dig_pin) < PIN_COUNT, "digital check on missing pin")
    `PMP_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !rx.ready, "request taken while decoding")

endmodule

`default_nettype wire

// ===== rtl/pmp_frame_buf.sv =====
`default_nettype none

module pmp_frame_buf (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [pmp_pkg::FA_W-1:0] wr_addr,
    input  wire logic [7:0]            wr_data,
    input  wire logic [pmp_pkg::FA_W-1:0] rd_addr,
    output logic      [7:0]            rd_data
);
    import pmp_pkg::*;

    logic [7:0] mem [FRAME_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pmp_pin_tbl.sv =====
`default_nettype none

module pmp_pin_tbl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pmp_pkg::pin_req_t req,
    output pmp_pkg::pin_rsp_t      rsp
);
    import pmp_pkg::*;

    logic [27:0]          mv_mem [PIN_COUNT];
    logic [6:0]           ch_mem [PIN_COUNT];
    logic [PIN_COUNT-1:0] mv_vld_reg;
    logic [PIN_COUNT-1:0] ch_vld_reg;
    pin_rsp_t             rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_vld_reg <= '0;
            ch_vld_reg <= '0;
        end
        else
        begin
            if (req.mv_we)
            begin
                mv_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.ch_we)
            begin
                ch_vld_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.mv_we)
        begin
            mv_mem[req.wr_addr] <= {req.mode, req.value};
        end
        if (req.ch_we)
        begin
            ch_mem[req.wr_addr] <= req.channel;
        end
        rsp_reg.mode    <= mv_vld_reg[req.rd_addr] ? mv_mem[req.rd_addr][27:21] : MODE_IN;
        rsp_reg.value   <= mv_vld_reg[req.rd_addr] ? mv_mem[req.rd_addr][20:0] : 21'd0;
        rsp_reg.channel <= ch_vld_reg[req.rd_addr] ? ch_mem[req.rd_addr] : CH_NONE;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== sim/pin_report_message_parser_unit_tb.sv =====
`timescale 1ns / 100ps

module pin_report_message_parser_unit_tb;
    import pmp_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [6:0]  pin;
        logic [20:0] value;
        logic [6:0]  mode;
        logic        last;
    } pin_event_t;

    class pin_event_scoreboard;
        logic [7:0]  frame_bytes [FRAME_DEPTH];
        int          frame_count;
        int          frame_target;
        logic [6:0]  pin_mode_tab [PIN_COUNT];
        logic [20:0] pin_value_tab [PIN_COUNT];
        logic [6:0]  pin_chan_tab [PIN_COUNT];
        pin_event_t  pending_events [$];
        pin_event_t  byte_events [$];
        int          errors;
        int          events_seen;
        int          requests_seen;

        function new();
            frame_count = 0;
            frame_target = 0;
            errors = 0;
            events_seen = 0;
            requests_seen = 0;
            for (int p = 0; p < PIN_COUNT; p++)
            begin
                pin_mode_tab[p] = MODE_IN;
                pin_value_tab[p] = '0;
                pin_chan_tab[p] = CH_NONE;
            end
        endfunction

        function void add_event(logic kind, int p);
            pin_event_t e;
            e.kind = kind;
            e.pin = p[6:0];
            e.value = pin_value_tab[p];
            e.mode = pin_mode_tab[p];
            e.last = 1'b0;
            byte_events.push_back(e);
        endfunction

        function void decode_frame();
            logic [7:0] head;
            int         n;
            int         p;
            logic [20:0] v;
            logic [13:0] bits;
            head = frame_bytes[0];
            n = frame_count;
            if (head[7:4] == HI_ANALOG && n == 3)
            begin
                v = {7'd0, frame_bytes[2][6:0], frame_bytes[1][6:0]};
                v = frame_bytes[1] | (frame_bytes[2] << 7);
                for (p = 0; p < PIN_COUNT; p++)
                begin
                    if (pin_chan_tab[p] == {3'd0, head[3:0]})
                    begin
                        pin_value_tab[p] = v;
                        add_event(EV_CHANGED, p);
                        return;
                    end
                end
                return;
            end
            if (head[7:4] == HI_DIGITAL && n == 3)
            begin
                bits = frame_bytes[1] | (frame_bytes[2] << 7);
                for (int b = 0; b < 8; b++)
                begin
                    p = head[3:0] * 8 + b;
                    if (p >= PIN_COUNT)
                        continue;
                    if (pin_mode_tab[p] == MODE_IN && pin_value_tab[p] != {20'd0, bits[b]})
                    begin
                        pin_value_tab[p] = {20'd0, bits[b]};
                        add_event(EV_CHANGED, p);
                    end
                end
                return;
            end
            if (head == B_SYSEX_BEGIN && n >= 2 && frame_bytes[n-1] == B_SYSEX_END)
            begin
                if (frame_bytes[1] == SUB_ANALOG_MAP)
                begin
                    for (int i = 2; i + 1 < n; i++)
                        if (i - 2 < PIN_COUNT)
                            pin_chan_tab[i-2] = frame_bytes[i][6:0];
                end
                else if (frame_bytes[1] == SUB_PIN_STATE && n >= 6)
                begin
                    p = frame_bytes[2];
                    if (p >= PIN_COUNT)
                        return;
                    pin_mode_tab[p] = frame_bytes[3][6:0];
                    v = frame_bytes[4];
                    if (n > 6)
                        v = v | (frame_bytes[5] << 7);
                    if (n > 7)
                        v = v | (frame_bytes[6] << 14);
                    pin_value_tab[p] = v;
                    add_event(EV_FOUND, p);
                end
            end
        endfunction

        function void note_request(logic [7:0] b);
            requests_seen++;
            byte_events.delete();
            if (b[7:4] == HI_ANALOG || b[7:4] == HI_DIGITAL || b == B_REPORT_VER)
            begin
                frame_target = 3;
                frame_count = 0;
            end
            else if (b[7:4] == HI_PROG || b[7:4] == HI_CHPRES)
            begin
                frame_target = 2;
                frame_count = 0;
            end
            else if (b == B_SYSEX_BEGIN)
            begin
                frame_target = FRAME_DEPTH;
                frame_count = 0;
            end
            else if (b == B_SYSEX_END)
                frame_target = frame_count + 1;
            else if (b[7])
            begin
                frame_target = 1;
                frame_count = 0;
            end
            if (frame_count < FRAME_DEPTH)
            begin
                frame_bytes[frame_count] = b;
                frame_count++;
            end
            if (frame_count == frame_target)
            begin
                decode_frame();
                frame_count = 0;
                frame_target = 0;
            end
            if (byte_events.size() > 0)
                byte_events[byte_events.size()-1].last = 1'b1;
            foreach (byte_events[i])
                pending_events.push_back(byte_events[i]);
        endfunction

        function void check_event(pin_event_t act);
            pin_event_t exp;
            events_seen++;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event kind=%0d pin=%0d value=%0h mode=%0d last=%0d",
                         $time, act.kind, act.pin, act.value, act.mode, act.last);
                errors++;
                return;
            end
            exp = pending_events.pop_front();
            if (exp != act)
            begin
                $display("%0t: event mismatch expected kind=%0d pin=%0d value=%0h mode=%0d last=%0d",
                         $time, exp.kind, exp.pin, exp.value, exp.mode, exp.last);
                $display("%0t:                  actual kind=%0d pin=%0d value=%0h mode=%0d last=%0d",
                         $time, act.kind, act.pin, act.value, act.mode, act.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    pmp_rx_if rx();
    pmp_ev_if ev();

    pin_report_message_parser_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx.sink),
        .ev    (ev.source)
    );

    pin_event_scoreboard sb;
    int  burst_left;
    int  idle_cycles;
    bit  long_hold_go;
    bit  long_hold_taken;
    int  hold_left;
    int  stall_phase;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        rx.valid = 1'b0;
        rx.rx_byte = 8'h00;
        ev.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: checks accepted events and stalls on its own pattern
    always @(posedge clk)
    begin
        pin_event_t act;
        if (rst_n)
        begin
            if (ev.valid && ev.ready)
            begin
                act = {ev.event_kind, ev.pin_number, ev.pin_value, ev.pin_mode, ev.last_event};
                sb.check_event(act);
                idle_cycles = 0;
            end
            if (long_hold_go && !long_hold_taken)
            begin
                long_hold_taken = 1'b1;
                hold_left = 400;
            end
            stall_phase = stall_phase + 1;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                ev.ready <= 1'b0;
            end
            else if ((stall_phase % 600) < 150)
                ev.ready <= 1'b1;
            else
                ev.ready <= ($urandom_range(0, 3) != 0) || (stall_phase % 7 == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= 3000)
            begin
                $display("%0t: watchdog expired, %0d events outstanding",
                         $time, sb.pending_events.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                rx.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        sb.note_request(b);
        idle_cycles = 0;
    endtask

    task automatic send_analog_map(input int len, input bit small_ch);
        send_byte(B_SYSEX_BEGIN);
        send_byte(SUB_ANALOG_MAP);
        for (int i = 0; i < len; i++)
            send_byte(small_ch ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 127)));
        send_byte(B_SYSEX_END);
    endtask

    task automatic send_pin_state(input int pin, input int mode, input int nval);
        send_byte(B_SYSEX_BEGIN);
        send_byte(SUB_PIN_STATE);
        send_byte(8'(pin));
        send_byte(8'(mode));
        for (int i = 0; i < nval; i++)
            send_byte(8'($urandom_range(0, 127)));
        send_byte(B_SYSEX_END);
    endtask

    task automatic send_random_message();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            send_byte({HI_ANALOG, 4'($urandom_range(0, 15))});
            send_byte(8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
        end
        else if (sel < 50)
        begin
            send_byte({HI_DIGITAL, 4'($urandom_range(0, 15))});
            send_byte(8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
        end
        else if (sel < 58)
            send_analog_map($urandom_range(0, 20), $urandom_range(0, 1));
        else if (sel < 72)
            send_pin_state($urandom_range(0, 127), $urandom_range(0, 2) == 0 ?
                           $urandom_range(0, 127) : 0, $urandom_range(0, 4));
        else if (sel < 80)
        begin
            send_byte({$urandom_range(0, 1) ? HI_PROG : HI_CHPRES, 4'($urandom_range(0, 15))});
            send_byte(8'($urandom_range(0, 127)));
        end
        else if (sel < 86)
        begin
            send_byte(B_SYSEX_BEGIN);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 127)));
            send_byte(B_SYSEX_END);
        end
        else
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        idle_cycles = 0;
        stall_phase = 0;
        hold_left = 0;
        long_hold_go = 1'b0;
        long_hold_taken = 1'b0;
        burst_left = 0;
        @(posedge rst_n);
        @(posedge clk);

        send_byte(B_SYSEX_BEGIN); send_byte(SUB_ANALOG_MAP);
        send_byte(8'd0); send_byte(8'd1); send_byte(8'd1); send_byte(8'd15);
        send_byte(B_SYSEX_END);
        send_byte(8'hE1); send_byte(8'h7F); send_byte(8'h7F);
        send_byte(8'hEF); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hE9); send_byte(8'h12); send_byte(8'h34);
        send_byte(8'h90); send_byte(8'h7F); send_byte(8'h01);
        send_byte(8'h9F); send_byte(8'h55); send_byte(8'h00);
        send_pin_state(127, 127, 3);
        send_pin_state(0, 1, 1);
        send_pin_state(2, 0, 2);
        send_byte(8'hC3); send_byte(8'h05);
        send_byte(8'hD2); send_byte(8'h01);
        send_byte(B_REPORT_VER); send_byte(8'h02); send_byte(8'h03);
        send_byte(8'hFF); send_byte(B_SYSEX_END);

        while (sb.requests_seen < 60)
            send_random_message();

        long_hold_go = 1'b1;
        repeat (8)
        begin
            send_byte({HI_DIGITAL, 4'($urandom_range(0, 15))});
            send_byte(8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
        end

        rx.valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        send_byte(B_SYSEX_BEGIN);
        repeat (FRAME_DEPTH - 1) send_byte(8'($urandom_range(0, 127)));

        rx.valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("Run covered %0d bytes and %0d events: analog, digital, mapping,",
                 sb.requests_seen, sb.events_seen);
        $display("pin state replies, a full sysex frame, noise and long stalls.");
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
